/* sv/top_k_max_heap_unit_macros.svh */
// Assertion macros for the top-k heap unit.
// Used by top_k_max_heap_unit.sv; expects clk and rst in scope.
`ifndef TOP_K_MAX_HEAP_UNIT_MACROS_SVH
`define TOP_K_MAX_HEAP_UNIT_MACROS_SVH

// same-cycle implication
`define TKMH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TKMH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tkmh_pkg.sv */
// Shared constants and types for the top-k max-heap unit.
// No dependencies.
package tkmh_pkg;

  localparam int DIST_W             = 32;
  localparam int ID_W               = 16;
  localparam int K_W                = 7;
  localparam int DEFAULT_HEAP_DEPTH = 64;
  localparam logic [K_W-1:0] K_RESET = 7'd64;

  localparam int ENTRY_W = DIST_W + ID_W;

  // action codes on s_tuser
  localparam logic ACT_OFFER = 1'b0;
  localparam logic ACT_POP   = 1'b1;

  // register index 0: k_limit
  localparam logic [1:0] REG_K_LIMIT = 2'd0;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [ID_W-1:0]   id;
  } entry_t;

endpackage

/* sv/tkmh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tkmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/top_k_max_heap_unit.sv */
// Top-k max-heap unit: keeps the K smallest offered distances (unsigned Q16.16) with
// their ids in a binary max-heap held in one RAM (tkmh_ram, uses tkmh_pkg). An offer
// is inserted while fewer than K entries are held; once full it replaces the largest
// entry only when strictly smaller. A pop returns the largest entry. One item is in
// work at a time, following the heap's single RAM read port: a reject or an empty pop
// goes straight to the result, an insert lifts the new entry level by level, a pop sinks
// the moved entry level by level, and a replacement runs the pop and then the insert.
// A new item is taken while a finished result still waits on the master side.
// The heap contents need no clearing after reset; only the state, entry count, K limit
// and output valid flag are reset.
`include "top_k_max_heap_unit_macros.svh"

module top_k_max_heap_unit
  import tkmh_pkg::*;
#(
  parameter int HEAP_DEPTH = DEFAULT_HEAP_DEPTH,
  localparam int CNT_W     = $clog2(HEAP_DEPTH + 1),
  localparam int RAW_W     = 2 + DIST_W + ID_W + CNT_W + DIST_W,
  localparam int OUT_W     = ((RAW_W + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input items
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [47:0]        s_tdata,   // offer_distance[31:0], offer_id[47:32]
  input  logic [0:0]         s_tuser,   // action[0]
  // result items
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata    // accepted, pop_valid, popped_distance,
                                        // popped_id, entry_count, top_distance, zero pad
);

  localparam int AW    = $clog2(HEAP_DEPTH);
  localparam int CMP_W = (CNT_W > K_W) ? CNT_W : K_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DN_GET   = 4'd1;
  localparam logic [3:0] S_DN_CHK   = 4'd2;
  localparam logic [3:0] S_DN_RIGHT = 4'd3;
  localparam logic [3:0] S_DN_CMP   = 4'd4;
  localparam logic [3:0] S_UP_INIT  = 4'd5;
  localparam logic [3:0] S_UP_CHK   = 4'd6;
  localparam logic [3:0] S_UP_CMP   = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]        state;
  logic [CNT_W-1:0]  count;
  logic [K_W-1:0]    k_limit;
  logic [CNT_W-1:0]  pos;        // current heap slot, 1-based
  entry_t            top_ent;    // copy of slot 1
  entry_t            mv;         // entry sinking from the root
  entry_t            off;        // offered entry rising from the bottom
  entry_t            ld;         // left child during sift-down
  logic              is_pop;
  logic              res_acc;
  logic              res_pop;
  entry_t            res_ent;
  logic              out_valid;
  logic [OUT_W-1:0]  out_data;

  // heap RAM ports
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [ENTRY_W-1:0] rd_raw;
  entry_t            rd_ent;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;

  logic              in_beat;
  logic              in_act;
  entry_t            in_ent;
  logic [CMP_W-1:0]  k_ext;
  logic [CMP_W-1:0]  cap;
  logic              has_room;
  logic              start_remove;
  logic [CNT_W:0]    left;
  logic [CNT_W:0]    right;
  logic [CNT_W:0]    count_x;
  logic              left_ok;
  logic              pick_left;
  entry_t            child_ent;
  logic [CNT_W:0]    child_idx;
  logic              sink;
  logic              rise;
  logic [AW-1:0]     pos_addr;
  logic              cfg_wr;

  tkmh_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HEAP_DEPTH)
  ) u_heap_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_ent = rd_raw;

  // config port: single register, every address decodes to it
  assign pready = 1'b1;
  assign prdata = 32'(k_limit);
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[1:0] >= REG_K_LIMIT);

  assign s_tready        = (state == S_IDLE);
  assign in_beat         = s_tvalid && s_tready;
  assign in_act          = s_tuser[0];
  assign in_ent.distance = s_tdata[31:0];
  assign in_ent.id       = s_tdata[47:32];

  // capacity = k_limit clamped to 1..HEAP_DEPTH
  assign k_ext    = CMP_W'(k_limit);
  assign cap      = (k_limit == '0) ? CMP_W'(1)
                  : ((k_ext > CMP_W'(HEAP_DEPTH)) ? CMP_W'(HEAP_DEPTH) : k_ext);
  assign has_room = CMP_W'(count) < cap;

  assign start_remove = in_beat && (count != '0) &&
                        ((in_act == ACT_POP) ||
                         (!has_room && (in_ent.distance < top_ent.distance)));

  assign left      = {pos, 1'b0};
  assign right     = {pos, 1'b1};
  assign count_x   = {1'b0, count};
  assign left_ok   = left <= count_x;
  // left wins only when strictly larger, or when there is no right child
  assign pick_left = (right > count_x) || (ld.distance > rd_ent.distance);
  assign child_ent = pick_left ? ld : rd_ent;
  assign child_idx = pick_left ? left : right;
  assign sink      = child_ent.distance > mv.distance;
  assign rise      = off.distance > rd_ent.distance;
  assign pos_addr  = AW'(pos - 1'b1);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos_addr;
    wr_data = mv;
    case (state)
      S_IDLE: begin
        if (start_remove) begin
          rd_en   = 1'b1;
          rd_addr = AW'(count - 1'b1);
        end
      end
      S_DN_CHK: begin
        if (left_ok) begin
          rd_en   = 1'b1;
          rd_addr = AW'(left - 1'b1);
        end else begin
          wr_en = 1'b1;
        end
      end
      S_DN_RIGHT: begin
        rd_en   = 1'b1;
        rd_addr = AW'(left);
      end
      S_DN_CMP: begin
        wr_en   = 1'b1;
        wr_data = sink ? child_ent : mv;
      end
      S_UP_CHK: begin
        if (pos == CNT_W'(1)) begin
          wr_en   = 1'b1;
          wr_data = off;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'((pos >> 1) - 1'b1);
        end
      end
      S_UP_CMP: begin
        wr_en   = 1'b1;
        wr_data = rise ? rd_ent : off;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      k_limit   <= K_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        k_limit <= pwdata[K_W-1:0];
      end
      if ((state == S_DONE) && (!out_valid || m_tready)) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_beat) begin
            off     <= in_ent;
            is_pop  <= (in_act == ACT_POP);
            res_acc <= (in_act == ACT_OFFER) && (has_room || start_remove);
            res_pop <= (in_act == ACT_POP) && (count != '0);
            res_ent <= ((in_act == ACT_POP) && (count != '0)) ? top_ent : '0;
            if (start_remove) begin
              count <= count - 1'b1;
              pos   <= CNT_W'(1);
              state <= S_DN_GET;
            end else if ((in_act == ACT_OFFER) && has_room) begin
              state <= S_UP_INIT;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DN_GET: begin
          mv <= rd_ent;   // last entry, moved to the root
          if (count == '0) begin
            state <= is_pop ? S_DONE : S_UP_INIT;
          end else begin
            state <= S_DN_CHK;
          end
        end
        S_DN_CHK: begin
          if (left_ok) begin
            state <= S_DN_RIGHT;
          end else begin
            state <= is_pop ? S_DONE : S_UP_INIT;
          end
        end
        S_DN_RIGHT: begin
          ld    <= rd_ent;
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (sink) begin
            pos   <= child_idx[CNT_W-1:0];
            state <= S_DN_CHK;
          end else begin
            state <= is_pop ? S_DONE : S_UP_INIT;
          end
        end
        S_UP_INIT: begin
          count <= count + 1'b1;
          pos   <= count + 1'b1;
          state <= S_UP_CHK;
        end
        S_UP_CHK: begin
          state <= (pos == CNT_W'(1)) ? S_DONE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (rise) begin
            pos   <= pos >> 1;
            state <= S_UP_CHK;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload: root copy tracks every write to slot 1, result word built on hand-off
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == '0)) begin
      top_ent <= wr_data;
    end
    if ((state == S_DONE) && (!out_valid || m_tready)) begin
      out_data <= OUT_W'({((count != '0) ? top_ent.distance : {DIST_W{1'b1}}),
                          count, res_ent.id, res_ent.distance, res_pop, res_acc});
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  `TKMH_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(HEAP_DEPTH),
    "entry count above heap depth")
  `TKMH_ASSERT_NEXT(a_beat_busy, in_beat, state != S_IDLE,
    "accepted beat left sequencer idle")
  `TKMH_ASSERT_NOW(a_write_busy, (state == S_IDLE) || (state == S_DONE), !wr_en,
    "heap write outside an operation")
  `TKMH_ASSERT_NEXT(a_count_step, 1'b1,
    (count == $past(count)) || (count == $past(count) + 1'b1) ||
    (count == $past(count) - 1'b1),
    "entry count moved by more than one")

endmodule

/* bench/top_k_max_heap_unit_tb.sv */
// Testbench for top_k_max_heap_unit: drives offer and pop beats, checks every result
// beat against a max-heap tracker kept in a small class. Depends on tkmh_pkg and the RTL.
`timescale 1ns / 1ps

module top_k_max_heap_unit_tb;
  import tkmh_pkg::*;

  localparam int HEAP_DEPTH  = DEFAULT_HEAP_DEPTH;
  localparam int CNT_W       = $clog2(HEAP_DEPTH + 1);
  localparam int RAW_W       = 2 + DIST_W + ID_W + CNT_W + DIST_W;
  localparam int OUT_W       = ((RAW_W + 7) / 8) * 8;
  localparam int PD_LO       = 2;
  localparam int PID_LO      = PD_LO + DIST_W;
  localparam int CNT_LO      = PID_LO + ID_W;
  localparam int TOP_LO      = CNT_LO + CNT_W;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 60;

  localparam int PLAN_K   [10] = '{64, 5, 5, 1, 0, 127, 16, 33, 2, 100};
  localparam int PLAN_N   [10] = '{60, 40, 40, 30, 25, 40, 50, 40, 25, 30};
  localparam int PLAN_POP [10] = '{10, 15, 60, 25, 30, 30, 25, 35, 40, 50};

  typedef struct {
    bit              accepted;
    bit              pop_valid;
    bit [DIST_W-1:0] popped_distance;
    bit [ID_W-1:0]   popped_id;
    bit [K_W-1:0]    entry_count;
    bit [DIST_W-1:0] top_distance;
  } knn_answer_t;

  // Shadow of the kept-candidate heap; slot 0 unused, slots 1..held occupied.
  class knn_heap_shadow;
    bit [DIST_W-1:0] dist_slot [0:HEAP_DEPTH];
    bit [ID_W-1:0]   id_slot   [0:HEAP_DEPTH];
    int unsigned     held;
    int unsigned     k_reg;
    knn_answer_t     awaited[$];
    int unsigned     errors, n_items, n_taken, n_rejected, n_popped, n_empty;

    function new();
      held  = 0;
      k_reg = K_RESET;
    endfunction

    function void set_limit(bit [K_W-1:0] k);
      k_reg = k;
    endfunction

    function int unsigned pending_count();
      return awaited.size();
    endfunction

    function bit [DIST_W-1:0] peak();
      return (held > 0) ? dist_slot[1] : '1;
    endfunction

    function int unsigned room();
      if (k_reg < 1) return 1;
      if (k_reg > HEAP_DEPTH) return HEAP_DEPTH;
      return k_reg;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      bit [DIST_W-1:0] d;
      bit [ID_W-1:0]   i;
      d = dist_slot[a]; i = id_slot[a];
      dist_slot[a] = dist_slot[b]; id_slot[a] = id_slot[b];
      dist_slot[b] = d; id_slot[b] = i;
    endfunction

    function void sift_in(bit [DIST_W-1:0] d, bit [ID_W-1:0] i);
      int unsigned c;
      if (held >= HEAP_DEPTH) return;
      held++;
      dist_slot[held] = d;
      id_slot[held]   = i;
      c = held;
      while (c > 1 && dist_slot[c] > dist_slot[c / 2]) begin
        swap_slots(c, c / 2);
        c = c / 2;
      end
    endfunction

    // right child wins ties
    function int unsigned larger_child(int unsigned c);
      if (c + 1 <= held && !(dist_slot[c] > dist_slot[c + 1])) return c + 1;
      return c;
    endfunction

    function void take_top(output bit [DIST_W-1:0] d, output bit [ID_W-1:0] i);
      int unsigned p, c;
      d = dist_slot[1];
      i = id_slot[1];
      swap_slots(1, held);
      held--;
      p = 1;
      c = larger_child(2);
      while (c <= held && dist_slot[c] > dist_slot[p]) begin
        swap_slots(c, p);
        p = c;
        c = larger_child(2 * p);
      end
    endfunction

    function void absorb_item(logic act, bit [DIST_W-1:0] d, bit [ID_W-1:0] i);
      knn_answer_t a;
      bit [DIST_W-1:0] dd;
      bit [ID_W-1:0]   di;
      a = '{default: 0};
      n_items++;
      if (act == ACT_OFFER) begin
        if (held < room()) begin
          sift_in(d, i);
          a.accepted = 1'b1;
        end else if (held > 0 && d < dist_slot[1]) begin
          take_top(dd, di);
          sift_in(d, i);
          a.accepted = 1'b1;
        end
        if (a.accepted) n_taken++; else n_rejected++;
      end else if (held > 0) begin
        take_top(a.popped_distance, a.popped_id);
        a.pop_valid = 1'b1;
        n_popped++;
      end else begin
        n_empty++;
      end
      a.entry_count  = held[K_W-1:0];
      a.top_distance = peak();
      awaited.push_back(a);
    endfunction

    function void check_field(string label, bit [DIST_W-1:0] want, logic [DIST_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
        errors++;
      end
    endfunction

    function void check_answer(logic [OUT_W-1:0] beat);
      knn_answer_t a;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $time, beat);
        errors++;
        return;
      end
      a = awaited.pop_front();
      check_field("accepted", a.accepted, beat[0]);
      check_field("pop_valid", a.pop_valid, beat[1]);
      check_field("popped_distance", a.popped_distance, beat[PD_LO +: DIST_W]);
      check_field("popped_id", a.popped_id, beat[PID_LO +: ID_W]);
      check_field("entry_count", a.entry_count, beat[CNT_LO +: CNT_W]);
      check_field("top_distance", a.top_distance, beat[TOP_LO +: DIST_W]);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [1:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [47:0]       s_tdata = '0;   // offer_distance[31:0], offer_id[47:32]
  logic [0:0]        s_tuser = '0;   // action[0]
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;        // accepted, pop_valid, popped_distance, popped_id,
                                     // entry_count, top_distance, zero pad

  bit source_lazy = 1'b1;
  bit sink_lazy   = 1'b1;
  bit hold_req    = 1'b0;

  knn_heap_shadow shadow = new();

  top_k_max_heap_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // beats are taken from pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        shadow.absorb_item(s_tuser[0], s_tdata[DIST_W-1:0], s_tdata[DIST_W +: ID_W]);
      if (m_tvalid && m_tready)
        shadow.check_answer(m_tdata);
    end
  end

  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (rst) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= !sink_lazy || ($urandom_range(99) >= 24);
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_item(input logic act, input bit [DIST_W-1:0] d, input bit [ID_W-1:0] i);
    while (source_lazy && $urandom_range(99) < 24) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {i, d};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // register writes only with the heap idle and nothing outstanding
  task automatic write_k(input bit [K_W-1:0] k);
    s_tvalid <= 1'b0;
    // let the monitor log the last accepted beat first
    @(posedge clk);
    while (shadow.pending_count() != 0) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_K_LIMIT;
    pwdata  <= 32'(k);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow.set_limit(k);
  endtask

  function automatic bit [DIST_W-1:0] pick_distance();
    bit [DIST_W-1:0] pk;
    pk = shadow.peak();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(31);
      4, 5, 6:    return $urandom;
      7:          return ($urandom_range(1) != 0) ? '1 : '0;
      default:    return pk + DIST_W'($urandom_range(2)) - 1;  // near the current largest
    endcase
  endfunction

  task automatic send_random(input int pop_pct);
    bit [ID_W-1:0] i;
    i = ID_W'(($urandom_range(9) == 0) ? (($urandom_range(1) != 0) ? '1 : '0)
                                       : $urandom_range(65535));
    if ($urandom_range(99) < pop_pct) send_item(ACT_POP, $urandom, i);
    else send_item(ACT_OFFER, pick_distance(), i);
  endtask

  initial begin : stimulus
    int guard;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default K: empty pop, field extremes, equal distances, drain to empty
    send_item(ACT_POP, '0, '0);
    send_item(ACT_OFFER, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(ACT_OFFER, 32'h0000_0000, 16'h0000);
    send_item(ACT_OFFER, 32'h8000_0000, 16'h1234);
    send_item(ACT_OFFER, 32'h8000_0000, 16'h5678);
    send_item(ACT_OFFER, 32'h0001_0000, 16'h0001);
    repeat (6) send_item(ACT_POP, '1, '1);

    // K of zero acts as one; equal offer to a full heap is rejected
    write_k(7'd0);
    send_item(ACT_OFFER, 32'd5, 16'hAAAA);
    send_item(ACT_OFFER, 32'd5, 16'h5555);
    send_item(ACT_OFFER, 32'd3, 16'h0F0F);
    send_item(ACT_OFFER, 32'hFFFF_FFFF, 16'hF0F0);
    send_item(ACT_POP, '0, '0);
    send_item(ACT_POP, '0, '0);

    write_k(7'd3);
    send_item(ACT_OFFER, 32'd10, 16'd10);
    send_item(ACT_OFFER, 32'd20, 16'd20);
    send_item(ACT_OFFER, 32'd30, 16'd30);
    send_item(ACT_OFFER, 32'd40, 16'd40);
    send_item(ACT_OFFER, 32'd15, 16'd15);

    // K lowered below the held count: offers only replace the largest
    write_k(7'd1);
    send_item(ACT_OFFER, 32'd1, 16'd1);
    send_item(ACT_OFFER, 32'd100, 16'd100);
    send_item(ACT_POP, '0, '0);

    for (int ph = 0; ph < 10; ph++) begin
      write_k(K_W'(PLAN_K[ph]));
      source_lazy = !(ph == 3 || ph == 4);
      sink_lazy   = !(ph == 3 || ph == 4);
      if (ph == 6) begin
        source_lazy = 1'b0;
        hold_req    = 1'b1;
      end
      for (int n = 0; n < PLAN_N[ph]; n++) send_random(PLAN_POP[ph]);
    end

    s_tvalid <= 1'b0;
    guard = 0;
    while (shadow.pending_count() != 0 && guard < 100_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d items: %0d offers kept, %0d rejected, %0d pops, %0d empty pops",
             shadow.n_items, shadow.n_taken, shadow.n_rejected, shadow.n_popped,
             shadow.n_empty);
    $display("K settings swept from 0 to 127, with a long result stall and idle-free stretches");
    if (shadow.errors == 0 && shadow.pending_count() == 0) begin
      $display("SUCCESS");
    end else begin
      if (shadow.pending_count() != 0)
        $display("%0t: %0d results never arrived", $time, shadow.pending_count());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/tkmh_pkg.sv
sv/tkmh_ram.sv
sv/top_k_max_heap_unit.sv
bench/top_k_max_heap_unit_tb.sv
